// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hdl/pnt_pkg.sv =====
// Package for the pheromone neighbour table: codes, types, constants.
// No dependencies.
`default_nettype none
package pnt_pkg;
    localparam int DEPTH_DEF = 16;
    localparam logic [15:0] EVAP_RST = 16'd6554;
    localparam logic [31:0] EXPIRY_RST = 32'd1000;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0, ACT_DEL = 3'd1, ACT_REFRESH = 3'd2, ACT_EVAP = 3'd3,
        ACT_REINF = 3'd4, ACT_EXPIRE = 3'd5, ACT_SELECT = 3'd6, ACT_FIND = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_SELF = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_SINK = 2'd0, CFG_EVAP = 2'd1, CFG_EXPIRY = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [31:0] pheromone;
        logic [31:0] time_now;
        logic [15:0] message_id;
        logic [15:0] from_hop;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] hop_address;
        logic [3:0]  hop_index;
        logic        no_route;
        logic [4:0]  entries;
    } t_result;
endpackage
`default_nettype wire

// ===== hdl/pnt_cmd_fifo.sv =====
// Two-entry command queue between the input front and the table engine.
// Depends on pnt_pkg.
`default_nettype none
module pnt_cmd_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  pnt_pkg::t_cmd     i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output pnt_pkg::t_cmd     o_data,
    output logic              o_empty
);
    import pnt_pkg::*;
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/pnt_engine.sv =====
// Table engine: sequencer over the neighbour table memories, serial divider.
// Depends on pnt_pkg.
`default_nettype none
module pnt_engine #(
    parameter int DEPTH = pnt_pkg::DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_sink,
    input  wire logic [15:0]   i_evap,
    input  wire logic [31:0]   i_expiry,
    input  wire logic          i_cmd_valid,
    input  pnt_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    output pnt_pkg::t_result   o_res,
    input  wire logic          i_res_pop
);
    import pnt_pkg::*;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_MOVE  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_WB    = 10'b0001000000,
        S_OUT   = 10'b0010000000,
        S_MRD   = 10'b0100000000,
        S_SEL0  = 10'b1000000000
    } t_state;

    t_state r_st;
    t_cmd r_cmd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_kept;
    logic [IW-1:0] r_best;
    logic [31:0] r_bestp;
    logic [IW-1:0] r_k;
    logic [15:0] r_a0;

    logic [15:0] m_addr [DEPTH];
    logic [31:0] m_pher [DEPTH];
    logic [31:0] m_heard [DEPTH];
    logic [15:0] m_msg [DEPTH];
    logic [15:0] r_ra;
    logic [31:0] r_rp, r_rh;
    logic [15:0] r_rm;
    logic [IW-1:0] r_radr;

    logic r_wr_en;
    logic [IW-1:0] r_wr_adr;
    logic [15:0] r_wr_a, r_wr_m;
    logic [31:0] r_wr_p, r_wr_h;

    logic [47:0] r_num;
    logic [32:0] r_rem;
    logic [5:0] r_dc;
    logic [47:0] r_prod;
    t_result r_res;
    logic r_rv;

    assign o_res_valid = r_rv;
    assign o_res = r_res;
    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid && !r_rv;

    logic [16:0] dvsr;
    logic [32:0] rem_sh;
    logic [32:0] sum;
    assign dvsr = 17'h10000 - {1'b0, i_evap};
    assign rem_sh = {r_rem[31:0], r_num[47]};
    assign sum = {1'b0, (|r_num[47:32]) ? 32'hFFFFFFFF : r_num[31:0]}
               + {1'b0, r_cmd.pheromone};

    always_ff @(posedge i_clk) begin
        r_ra <= m_addr[r_radr];
        r_rp <= m_pher[r_radr];
        r_rh <= m_heard[r_radr];
        r_rm <= m_msg[r_radr];
        if (r_wr_en) begin
            m_addr[r_wr_adr] <= r_wr_a;
            m_pher[r_wr_adr] <= r_wr_p;
            m_heard[r_wr_adr] <= r_wr_h;
            m_msg[r_wr_adr] <= r_wr_m;
        end
    end

    logic [CW-1:0] idx_nx;
    logic last_i;
    assign idx_nx = r_i + CW'(1);
    assign last_i = (idx_nx >= r_cnt);

    always_ff @(posedge i_clk) begin
        r_wr_en <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_rv <= 1'b0;
        end else begin
            if (i_res_pop && r_rv) r_rv <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        r_res <= '{status: ST_OK, hop_address: 16'd0, hop_index: 4'd0,
                                   no_route: 1'b0, entries: 5'd0};
                        r_i <= '0;
                        r_radr <= '0;
                        r_best <= '0;
                        r_bestp <= '0;
                        r_kept <= CW'(1);
                        case (t_action'(i_cmd.action))
                            ACT_ADD: begin
                                if (r_cnt == CW'(DEPTH)) begin
                                    r_res.status <= ST_FULL;
                                    r_st <= S_OUT;
                                end else begin
                                    r_wr_en <= 1'b1;
                                    r_wr_adr <= r_cnt[IW-1:0];
                                    r_wr_a <= i_cmd.address;
                                    r_wr_p <= i_cmd.pheromone;
                                    r_wr_h <= i_cmd.time_now;
                                    r_wr_m <= i_cmd.message_id;
                                    r_res.hop_address <= i_cmd.address;
                                    r_res.hop_index <= 4'(r_cnt);
                                    r_cnt <= r_cnt + CW'(1);
                                    r_st <= S_OUT;
                                end
                            end
                            ACT_EXPIRE: begin
                                if (r_cnt > CW'(1)) begin
                                    r_i <= CW'(1);
                                    r_radr <= IW'(1);
                                    r_st <= S_RD;
                                end else r_st <= S_OUT;
                            end
                            ACT_SELECT: begin
                                if (r_cnt == '0) begin
                                    r_res.status <= ST_NOT_FOUND;
                                    r_res.no_route <= 1'b1;
                                    r_st <= S_OUT;
                                end else r_st <= S_RD;
                            end
                            default: begin
                                if (r_cnt == '0) begin
                                    r_res.status <= ST_NOT_FOUND;
                                    r_st <= S_OUT;
                                end else r_st <= S_RD;
                            end
                        endcase
                    end
                end
                S_RD: r_st <= S_SCAN;
                S_SCAN: begin
                    // r_r* hold entry r_i
                    r_st <= S_RD;
                    r_radr <= idx_nx[IW-1:0];
                    r_i <= idx_nx;
                    case (t_action'(r_cmd.action))
                        ACT_EXPIRE: begin
                            if ((r_cmd.time_now - r_rh) < i_expiry) begin
                                if (r_kept != r_i) begin
                                    r_wr_en <= 1'b1;
                                    r_wr_adr <= r_kept[IW-1:0];
                                    r_wr_a <= r_ra; r_wr_p <= r_rp;
                                    r_wr_h <= r_rh; r_wr_m <= r_rm;
                                end
                                r_kept <= r_kept + CW'(1);
                                if (last_i) r_cnt <= r_kept + CW'(1);
                            end else if (last_i) r_cnt <= r_kept;
                            if (last_i) r_st <= S_OUT;
                        end
                        ACT_SELECT: begin
                            if (r_i == '0) begin
                                r_a0 <= r_ra;
                                if (last_i) r_st <= S_SEL0;
                            end else if (r_ra == i_sink) begin
                                r_best <= r_i[IW-1:0];
                                r_st <= S_SEL0;
                            end else begin
                                if (r_rp > r_bestp && r_rm != r_cmd.message_id &&
                                    r_ra != r_cmd.from_hop) begin
                                    r_bestp <= r_rp;
                                    r_best <= r_i[IW-1:0];
                                end
                                if (last_i) r_st <= S_SEL0;
                            end
                        end
                        ACT_DEL: begin
                            if (r_i == '0 && r_ra == r_cmd.address) begin
                                r_res.status <= ST_SELF;
                                r_st <= S_OUT;
                            end else if (r_ra == r_cmd.address) begin
                                r_res.hop_address <= r_cmd.address;
                                r_res.hop_index <= 4'(r_i);
                                if (last_i) begin
                                    r_cnt <= r_cnt - CW'(1);
                                    r_st <= S_OUT;
                                end else begin
                                    r_k <= r_i[IW-1:0];
                                    r_st <= S_MRD;
                                end
                            end else if (last_i) begin
                                r_res.status <= ST_NOT_FOUND;
                                r_st <= S_OUT;
                            end
                        end
                        default: begin
                            if (r_ra == r_cmd.address) begin
                                r_res.hop_address <= r_cmd.address;
                                r_res.hop_index <= 4'(r_i);
                                r_k <= r_i[IW-1:0];
                                r_radr <= r_i[IW-1:0];
                                r_wr_adr <= r_i[IW-1:0];
                                r_wr_a <= r_ra; r_wr_p <= r_rp;
                                r_wr_h <= r_rh; r_wr_m <= r_rm;
                                case (t_action'(r_cmd.action))
                                    ACT_REFRESH: begin
                                        r_wr_en <= 1'b1;
                                        r_wr_h <= r_cmd.time_now;
                                        r_st <= S_OUT;
                                    end
                                    ACT_EVAP: begin
                                        r_prod <= r_rp * i_evap;
                                        r_st <= S_MUL;
                                    end
                                    ACT_REINF: begin
                                        r_num <= {r_rp, 16'd0};
                                        r_rem <= '0;
                                        r_dc <= 6'd48;
                                        r_st <= S_DIV;
                                    end
                                    default: r_st <= S_OUT;
                                endcase
                            end else if (last_i) begin
                                r_res.status <= ST_NOT_FOUND;
                                r_st <= S_OUT;
                            end
                        end
                    endcase
                end
                S_MRD: begin
                    // shift entries down: read k+1 then write k
                    r_radr <= IW'(r_k + IW'(1));
                    r_st <= S_MOVE;
                    r_dc <= 6'd0;
                end
                S_MOVE: begin
                    if (r_dc == 6'd0) r_dc <= 6'd1;
                    else begin
                        r_wr_en <= 1'b1;
                        r_wr_adr <= r_k;
                        r_wr_a <= r_ra; r_wr_p <= r_rp; r_wr_h <= r_rh; r_wr_m <= r_rm;
                        if (CW'(r_k) + CW'(2) >= r_cnt) begin
                            r_cnt <= r_cnt - CW'(1);
                            r_st <= S_OUT;
                        end else begin
                            r_k <= IW'(r_k + IW'(1));
                            r_st <= S_MRD;
                        end
                    end
                end
                S_MUL: begin
                    r_wr_en <= 1'b1;
                    r_wr_p <= r_wr_p - r_prod[47:16];
                    r_st <= S_OUT;
                end
                S_DIV: begin
                    if (r_dc == 6'd0) r_st <= S_WB;
                    else begin
                        r_dc <= r_dc - 6'd1;
                        if (rem_sh >= {16'd0, dvsr}) begin
                            r_rem <= rem_sh - {16'd0, dvsr};
                            r_num <= {r_num[46:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[46:0], 1'b0};
                        end
                    end
                end
                S_WB: begin
                    r_wr_en <= 1'b1;
                    r_wr_p <= sum[32] ? 32'hFFFFFFFF : sum[31:0];
                    r_st <= S_OUT;
                end
                S_SEL0: begin
                    if (r_best == '0) begin
                        r_res.no_route <= 1'b1;
                        r_res.hop_address <= r_a0;
                    end else begin
                        r_res.hop_address <= m_addr[r_best];
                        r_res.hop_index <= 4'(r_best);
                        r_wr_en <= 1'b1;
                        r_wr_adr <= r_best;
                        r_wr_a <= m_addr[r_best];
                        r_wr_p <= m_pher[r_best];
                        r_wr_h <= m_heard[r_best];
                        r_wr_m <= r_cmd.message_id;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_res.entries <= 5'(r_cnt);
                    r_rv <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/pheromone_neighbour_table_top.sv =====
// Channel   | Dir | Handshake                | Payload
// cmd       | in  | push / full              | action, address, pheromone, ...
// result    | out | empty / pop              | status, hop fields, entries
// config    | in  | i_cfg_valid / o_cfg_ready| index, data
// An item is started in idle, reads and scans each table entry in turn, then loads its result;
// reinforce adds the 48-step divider, its finish and write-back; delete moves each later entry down.
// Reset (i_rst_n low, synchronous) empties the table and queue; no clearing pass.
// A waiting result holds the engine until popped; the 2-entry queue keeps taking items until full.
// Depends on pnt_pkg, pnt_cmd_fifo, pnt_engine, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pheromone_neighbour_table_top #(
    parameter int TABLE_DEPTH = pnt_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [31:0] i_pheromone,
    input  wire logic [31:0] i_time_now,
    input  wire logic [15:0] i_message_id,
    input  wire logic [15:0] i_from_hop,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic [15:0]      o_hop_address,
    output logic [3:0]       o_hop_index,
    output logic             o_no_route,
    output logic [4:0]       o_entries,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import pnt_pkg::*;
    localparam logic [4:0] ENT_MAX = (TABLE_DEPTH > 31) ? 5'd31 : 5'(TABLE_DEPTH);
    logic [15:0] r_sink, r_evap;
    logic [31:0] r_expiry;
    t_cmd cmd_in, cmd_q;
    logic q_empty, q_pop, res_v;
    t_result res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sink <= 16'd0;
            r_evap <= EVAP_RST;
            r_expiry <= EXPIRY_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SINK:   r_sink <= i_cfg_data[15:0];
                CFG_EVAP:   r_evap <= i_cfg_data[15:0];
                CFG_EXPIRY: r_expiry <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cmd_in = '{action: i_action, address: i_address, pheromone: i_pheromone,
                      time_now: i_time_now, message_id: i_message_id,
                      from_hop: i_from_hop};

    pnt_cmd_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_data(cmd_in), .o_full(full),
        .i_pop(q_pop), .o_data(cmd_q), .o_empty(q_empty)
    );

    pnt_engine #(.DEPTH(TABLE_DEPTH)) u_eng (
        .i_clk, .i_rst_n, .i_sink(r_sink), .i_evap(r_evap), .i_expiry(r_expiry),
        .i_cmd_valid(!q_empty), .i_cmd(cmd_q), .o_cmd_pop(q_pop),
        .o_res_valid(res_v), .o_res(res), .i_res_pop(pop)
    );

    assign empty = !res_v;
    assign o_status = res.status;
    assign o_hop_address = res.hop_address;
    assign o_hop_index = res.hop_index;
    assign o_no_route = res.no_route;
    assign o_entries = res.entries;

    `ASSERT_IMPL(a_entries_max, i_clk, i_rst_n, !empty && TABLE_DEPTH < 32, o_entries <= ENT_MAX)
    `ASSERT_NEXT(a_hold_res, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_status))
    `ASSERT_IMPL(a_noroute_sel, i_clk, i_rst_n, !empty && o_no_route, o_hop_index == 4'd0)
endmodule
`default_nettype wire
